>>> rtl/pedestrian_crossing_light_controller_unit_assert.svh
// Assertion macros for the pedestrian crossing light controller.
// Used by pedestrian_crossing_light_controller_unit; needs signals clock and reset in scope.
`ifndef PEDESTRIAN_CROSSING_LIGHT_CONTROLLER_UNIT_ASSERT_SVH
`define PEDESTRIAN_CROSSING_LIGHT_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCLC_ASSERT_IMP(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("pclc assertion failed");

// Next-cycle implication, disabled during reset.
`define PCLC_ASSERT_NXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("pclc assertion failed");

`endif

>>> rtl/pclc_pkg.sv
// Package for the pedestrian crossing light controller: register map, reset values,
// stream widths and the seven-segment decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pclc_pkg;

   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 16;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [2:0] {
      REG_YELLOW_TICKS    = 3'd0,
      REG_COUNTDOWN_START = 3'd1,
      REG_STEP_TICKS      = 3'd2,
      REG_LOCKOUT_TICKS   = 3'd3,
      REG_MUX_TICKS       = 3'd4
   } reg_index_type;

   localparam logic [15:0] YELLOW_TICKS_RST    = 16'd3000;
   localparam logic [6:0]  COUNTDOWN_START_RST = 7'd30;
   localparam logic [9:0]  STEP_TICKS_RST      = 10'd500;
   localparam logic [15:0] LOCKOUT_TICKS_RST   = 16'd5000;
   localparam logic [7:0]  MUX_TICKS_RST       = 8'd5;

   localparam logic [7:0]  COUNT_BLANK = 8'hFF;
   localparam logic [6:0]  COUNT_MAX   = 7'd99;

   function automatic logic [6:0] seg_decode(input logic [3:0] digit);
      logic [6:0] segs;
      case (digit)
         4'd0: segs = 7'h3F;
         4'd1: segs = 7'h06;
         4'd2: segs = 7'h5B;
         4'd3: segs = 7'h4F;
         4'd4: segs = 7'h66;
         4'd5: segs = 7'h6D;
         4'd6: segs = 7'h7D;
         4'd7: segs = 7'h07;
         4'd8: segs = 7'h7F;
         4'd9: segs = 7'h6F;
         default: segs = 7'h3F;
      endcase
      return segs;
   endfunction

endpackage

`default_nettype wire

>>> rtl/pedestrian_crossing_light_controller_unit.sv
// Pedestrian crossing light controller: one request per millisecond tick carries the
// raw button level, one response per tick carries lamps and display. Uses pclc_pkg.
// Takes assertion macros from pedestrian_crossing_light_controller_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted request advances the controller by one tick: lockout and button latch,
// countdown and display multiplexer, then the phase machine, all in one combinational update.
// The response for a request is in the output register on the next cycle, and a new
// request is taken every cycle while that register is empty or being drained; the rate
// is one request per clock, since the state update is combinational. CSR writes are taken
// at any time but belong to idle periods. TIMER_BITS sizes the phase and lockout timers;
// yellow and lockout settings above their range saturate to the largest timer value.
module pedestrian_crossing_light_controller_unit
   import pclc_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [0] button_level, rest zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] car_green, [1] car_yellow, [2] car_red, [3] walk_green, [4] walk_red,
   // [11:5] segments, [12] tens_enable, [13] units_enable, [14] log_event, [15] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   typedef enum logic [1:0] {
      PH_GREEN  = 2'd0,
      PH_YELLOW = 2'd1,
      PH_WALK   = 2'd2,
      PH_SPARE  = 2'd3
   } phase_type;

   // configuration
   logic [15:0] yellow_ticks_ff;
   logic [6:0]  countdown_start_ff;
   logic [9:0]  step_ticks_ff;
   logic [15:0] lockout_ticks_ff;
   logic [7:0]  mux_ticks_ff;

   // controller state
   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] phase_timer_ff, phase_timer_in;
   logic [7:0]            count_ff, count_in;
   logic [9:0]            step_timer_ff, step_timer_in;
   logic [7:0]            mux_timer_ff, mux_timer_in;
   logic                  mux_digit_ff, mux_digit_in;
   logic                  latch_ff, latch_in;
   logic [TIMER_BITS-1:0] lockout_ff, lockout_in;

   // response register
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic req_accept;
   logic csr_write;
   reg_index_type csr_index;

   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_YELLOW_TICKS:    csr_prdata = CSR_DATA_W'(yellow_ticks_ff);
         REG_COUNTDOWN_START: csr_prdata = CSR_DATA_W'(countdown_start_ff);
         REG_STEP_TICKS:      csr_prdata = CSR_DATA_W'(step_ticks_ff);
         REG_LOCKOUT_TICKS:   csr_prdata = CSR_DATA_W'(lockout_ticks_ff);
         REG_MUX_TICKS:       csr_prdata = CSR_DATA_W'(mux_ticks_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yellow_ticks_ff    <= YELLOW_TICKS_RST;
         countdown_start_ff <= COUNTDOWN_START_RST;
         step_ticks_ff      <= STEP_TICKS_RST;
         lockout_ticks_ff   <= LOCKOUT_TICKS_RST;
         mux_ticks_ff       <= MUX_TICKS_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_YELLOW_TICKS:    yellow_ticks_ff    <= csr_pwdata[15:0];
            REG_COUNTDOWN_START: countdown_start_ff <= csr_pwdata[6:0];
            REG_STEP_TICKS:      step_ticks_ff      <= csr_pwdata[9:0];
            REG_LOCKOUT_TICKS:   lockout_ticks_ff   <= csr_pwdata[15:0];
            REG_MUX_TICKS:       mux_ticks_ff       <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // next state for one tick
   always_comb begin
      logic            pressed;
      logic            log_ev;
      logic [CW-1:0]   pt_ext;
      logic [CW-1:0]   mask_ext;
      logic [CW-1:0]   lk_ext;
      logic [6:0]      v;
      logic [14:0]     prod;
      logic [3:0]      tens;
      logic [6:0]      units;
      logic [6:0]      segs;
      logic            blank;

      pressed        = ~req_tdata[0];
      log_ev         = 1'b0;
      phase_in       = (phase_ff == PH_SPARE) ? PH_GREEN : phase_ff;
      phase_timer_in = phase_timer_ff;
      count_in       = count_ff;
      step_timer_in  = step_timer_ff;
      mux_timer_in   = mux_timer_ff;
      mux_digit_in   = mux_digit_ff;
      latch_in       = latch_ff;
      lockout_in     = lockout_ff;
      mask_ext       = CW'({TIMER_BITS{1'b1}});
      pt_ext         = '0;
      lk_ext         = CW'(lockout_ticks_ff);

      if (lockout_ff != '0) begin
         lockout_in = lockout_ff - 1'b1;
      end else if (phase_in == PH_GREEN && pressed) begin
         latch_in = 1'b1;
      end

      if (count_ff != COUNT_BLANK) begin
         step_timer_in = step_timer_ff + 1'b1;
         if (step_timer_in >= step_ticks_ff || step_timer_in == '0) begin
            step_timer_in = '0;
            count_in      = count_ff - 1'b1;
         end
         if (count_in == COUNT_BLANK) begin
            mux_timer_in = '0;
            mux_digit_in = 1'b0;
         end else begin
            mux_timer_in = mux_timer_ff + 1'b1;
            if (mux_timer_in >= mux_ticks_ff || mux_timer_in == '0) begin
               mux_timer_in = '0;
               mux_digit_in = ~mux_digit_ff;
            end
         end
      end

      case (phase_in)
         PH_GREEN: begin
            if (latch_in) begin
               log_ev         = 1'b1;
               phase_in       = PH_YELLOW;
               phase_timer_in = '0;
            end
         end
         PH_YELLOW: begin
            if (phase_timer_ff != '1) begin
               phase_timer_in = phase_timer_ff + 1'b1;
            end
            pt_ext = CW'(phase_timer_in);
            if (pt_ext >= CW'(yellow_ticks_ff) || pt_ext == mask_ext) begin
               phase_in       = PH_WALK;
               phase_timer_in = '0;
               count_in       = (countdown_start_ff > COUNT_MAX) ? {1'b0, COUNT_MAX}
                                                                 : {1'b0, countdown_start_ff};
               step_timer_in  = '0;
               mux_timer_in   = '0;
               mux_digit_in   = 1'b0;
            end
         end
         PH_WALK: begin
            if (count_in == '0 || count_in == COUNT_BLANK) begin
               phase_in   = PH_GREEN;
               latch_in   = 1'b0;
               lockout_in = (lk_ext > mask_ext) ? '1 : lk_ext[TIMER_BITS-1:0];
            end
         end
         default: phase_in = PH_GREEN;
      endcase

      // display decode: tens by reciprocal multiply, exact for values below 100
      blank = (count_in == COUNT_BLANK);
      v     = (count_in > 8'(COUNT_MAX)) ? COUNT_MAX : count_in[6:0];
      prod  = 15'(v) * 15'd205;
      tens  = prod[14:11];
      units = v - (7'(tens) * 7'd10);
      if (blank) begin
         segs = seg_decode(4'd0);
      end else if (mux_digit_in) begin
         segs = seg_decode(units[3:0]);
      end else begin
         segs = seg_decode(tens);
      end

      rsp_tdata_in       = '0;
      rsp_tdata_in[0]    = (phase_in == PH_GREEN);
      rsp_tdata_in[1]    = (phase_in == PH_YELLOW);
      rsp_tdata_in[2]    = (phase_in == PH_WALK);
      rsp_tdata_in[3]    = (phase_in == PH_WALK);
      rsp_tdata_in[4]    = (phase_in != PH_WALK);
      rsp_tdata_in[11:5] = segs;
      rsp_tdata_in[12]   = ~blank & ~mux_digit_in;
      rsp_tdata_in[13]   = ~blank & mux_digit_in;
      rsp_tdata_in[14]   = log_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_GREEN;
         phase_timer_ff <= '0;
         count_ff       <= COUNT_BLANK;
         step_timer_ff  <= '0;
         mux_timer_ff   <= '0;
         mux_digit_ff   <= 1'b0;
         latch_ff       <= 1'b0;
         lockout_ff     <= '0;
         rsp_tvalid_ff  <= 1'b0;
         rsp_tdata_ff   <= '0;
      end else begin
         if (req_accept) begin
            phase_ff       <= phase_in;
            phase_timer_ff <= phase_timer_in;
            count_ff       <= count_in;
            step_timer_ff  <= step_timer_in;
            mux_timer_ff   <= mux_timer_in;
            mux_digit_ff   <= mux_digit_in;
            latch_ff       <= latch_in;
            lockout_ff     <= lockout_in;
            rsp_tvalid_ff  <= 1'b1;
            rsp_tdata_ff   <= rsp_tdata_in;
         end else if (rsp_tready) begin
            rsp_tvalid_ff  <= 1'b0;
         end
      end
   end

`include "pedestrian_crossing_light_controller_unit_assert.svh"

   `PCLC_ASSERT_IMP(a_walk_not_blank, phase_ff == PH_WALK, count_ff != COUNT_BLANK)
   `PCLC_ASSERT_IMP(a_lockout_in_green, lockout_ff != '0, phase_ff == PH_GREEN)
   `PCLC_ASSERT_NXT(a_accept_gives_rsp, req_accept, rsp_tvalid_ff)

endmodule

`default_nettype wire
